// File: rtl/core/bbd_pkg.sv
// shared constants, codes and types of the bilinear bayer demosaic core
package bbd_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_FRAME_LINES = 4096;
  localparam int COL_W           = $clog2(MAX_LINE_PIXELS);
  localparam int OUT_ROW_W       = 12;
  localparam int IN_ROW_W        = 13;
  localparam int DIM_W           = 13;
  localparam int PIX_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = FIFO_PTR_W + 1;

  localparam logic [DIM_W-1:0] DEF_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] DEF_FRAME_HEIGHT = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_BAYER_PATTERN = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PAT_GRBG = 2'd0,
    PAT_RGGB = 2'd1,
    PAT_BGGR = 2'd2,
    PAT_GBRG = 2'd3
  } bayer_pat_t;

  typedef struct packed {
    logic emit;
    logic eof;
    logic inner;
    logic green_site;
    logic red_row;
  } pix_ctl_t;

  typedef struct packed {
    logic             eof;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_item_t;

endpackage

// File: rtl/core/bbd_pos_ctrl.sv
// configuration registers and raster position counters of the demosaic core
module bbd_pos_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            accept,
  output logic [bbd_pkg::COL_W-1:0]       col,
  output bbd_pkg::pix_ctl_t               ctl
);
  import bbd_pkg::*;

  logic [DIM_W-1:0]     frame_width;
  logic [DIM_W-1:0]     frame_height;
  bayer_pat_t           bayer_pattern;
  logic [DIM_W-1:0]     w_eff;
  logic [DIM_W-1:0]     h_eff;
  logic [COL_W-1:0]     in_col;
  logic [IN_ROW_W-1:0]  in_row;
  logic [COL_W-1:0]     out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic [DIM_W-1:0]     in_col_inc;
  logic [DIM_W-1:0]     out_col_inc;
  logic [DIM_W-1:0]     out_col_ext;
  logic [DIM_W-1:0]     out_row_ext;
  logic                 xo;
  logic                 yo;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_LINE_PIXELS)) begin
      w_eff = DIM_W'(MAX_LINE_PIXELS);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_FRAME_LINES)) begin
      h_eff = DIM_W'(MAX_FRAME_LINES);
    end else begin
      h_eff = frame_height;
    end
  end

  assign in_col_inc  = {{(DIM_W-COL_W){1'b0}}, in_col} + DIM_W'(1);
  assign out_col_ext = {{(DIM_W-COL_W){1'b0}}, out_col};
  assign out_row_ext = {{(DIM_W-OUT_ROW_W){1'b0}}, out_row};
  assign out_col_inc = out_col_ext + DIM_W'(1);
  assign xo          = out_col[0];
  assign yo          = out_row[0];
  assign col         = in_col;

  always_comb begin
    ctl.emit  = (in_row >= IN_ROW_W'(2)) || ((in_row == IN_ROW_W'(1)) && (in_col != '0));
    ctl.eof   = ctl.emit && (out_row_ext == h_eff - DIM_W'(1))
                && (out_col_ext == w_eff - DIM_W'(1));
    ctl.inner = (out_col != '0) && (out_row != '0)
                && (out_col_ext != w_eff - DIM_W'(1))
                && (out_row_ext != h_eff - DIM_W'(1));
    case (bayer_pattern) inside
      PAT_GRBG, PAT_GBRG: ctl.green_site = (xo == yo);
      default:            ctl.green_site = (xo != yo);
    endcase
    case (bayer_pattern) inside
      PAT_GRBG, PAT_RGGB: ctl.red_row = !yo;
      default:            ctl.red_row = yo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= DEF_FRAME_WIDTH;
      frame_height  <= DEF_FRAME_HEIGHT;
      bayer_pattern <= PAT_GRBG;
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
          in_col      <= '0;
          in_row      <= '0;
          out_col     <= '0;
          out_row     <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          in_col       <= '0;
          in_row       <= '0;
          out_col      <= '0;
          out_row      <= '0;
        end
        REG_BAYER_PATTERN: begin
          bayer_pattern <= bayer_pat_t'(cfg_data[1:0]);
          in_col        <= '0;
          in_row        <= '0;
          out_col       <= '0;
          out_row       <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (ctl.eof) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col_inc >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + IN_ROW_W'(1);
        end else begin
          in_col <= in_col_inc[COL_W-1:0];
        end
        if (ctl.emit) begin
          if (out_col_inc >= w_eff) begin
            out_col <= '0;
            out_row <= out_row + OUT_ROW_W'(1);
          end else begin
            out_col <= out_col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/bbd_line_store.sv
// two line memories with read, shift-down write back and same-column forwarding
module bbd_line_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [bbd_pkg::COL_W-1:0]   rd_col,
  input  logic [bbd_pkg::PIX_W-1:0]   px_in,
  output logic                        s1_valid,
  output logic [bbd_pkg::PIX_W-1:0]   s1_top,
  output logic [bbd_pkg::PIX_W-1:0]   s1_mid,
  output logic [bbd_pkg::PIX_W-1:0]   s1_px
);
  import bbd_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] middle_mem [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] middle_rd;
  logic [COL_W-1:0] s1_col;
  logic             fwd;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd  <= upper_mem[rd_col];
      middle_rd <= middle_mem[rd_col];
    end
    if (s1_valid) begin
      upper_mem[s1_col]  <= s1_mid;
      middle_mem[s1_col] <= s1_px;
    end
  end

  // write back of the previous item lands in the same cycle as this read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_col  <= rd_col;
      s1_px   <= px_in;
      fwd     <= s1_valid && (s1_col == rd_col);
      fwd_top <= s1_mid;
      fwd_mid <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
  end

  assign s1_top = fwd ? fwd_top : upper_rd;
  assign s1_mid = fwd ? fwd_mid : middle_rd;

endmodule

// File: rtl/core/bbd_interp.sv
// 3x3 window and bilinear color interpolation
module bbd_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s1_valid,
  input  logic [bbd_pkg::PIX_W-1:0]   s1_top,
  input  logic [bbd_pkg::PIX_W-1:0]   s1_mid,
  input  logic [bbd_pkg::PIX_W-1:0]   s1_px,
  input  bbd_pkg::pix_ctl_t           s1_ctl,
  output logic                        push,
  output bbd_pkg::rgb_item_t          item
);
  import bbd_pkg::*;

  logic [PIX_W-1:0] win [9];
  logic             s2_valid;
  pix_ctl_t         s2_ctl;
  logic [PIX_W+1:0] cross_sum;
  logic [PIX_W+1:0] diag_sum;
  logic [PIX_W:0]   horiz_sum;
  logic [PIX_W:0]   vert_sum;
  logic [PIX_W-1:0] cross_avg;
  logic [PIX_W-1:0] diag_avg;
  logic [PIX_W-1:0] horiz_avg;
  logic [PIX_W-1:0] vert_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r]   <= win[3*r+1];
        win[3*r+1] <= win[3*r+2];
      end
      win[2] <= s1_top;
      win[5] <= s1_mid;
      win[8] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_comb begin
    cross_sum = (PIX_W+2)'(win[1]) + (PIX_W+2)'(win[3]) + (PIX_W+2)'(win[5])
                + (PIX_W+2)'(win[7]);
    diag_sum  = (PIX_W+2)'(win[0]) + (PIX_W+2)'(win[2]) + (PIX_W+2)'(win[6])
                + (PIX_W+2)'(win[8]);
    horiz_sum = (PIX_W+1)'(win[3]) + (PIX_W+1)'(win[5]);
    vert_sum  = (PIX_W+1)'(win[1]) + (PIX_W+1)'(win[7]);
    cross_avg = cross_sum[PIX_W+1:2];
    diag_avg  = diag_sum[PIX_W+1:2];
    horiz_avg = horiz_sum[PIX_W:1];
    vert_avg  = vert_sum[PIX_W:1];

    item.eof   = s2_ctl.eof;
    item.red   = '0;
    item.green = '0;
    item.blue  = '0;
    if (s2_ctl.inner) begin
      if (s2_ctl.green_site) begin
        item.green = win[4];
        item.red   = s2_ctl.red_row ? horiz_avg : vert_avg;
        item.blue  = s2_ctl.red_row ? vert_avg : horiz_avg;
      end else if (s2_ctl.red_row) begin
        item.red   = win[4];
        item.green = cross_avg;
        item.blue  = diag_avg;
      end else begin
        item.blue  = win[4];
        item.green = cross_avg;
        item.red   = diag_avg;
      end
    end
  end

  assign push = s2_valid;

endmodule

// File: rtl/core/bbd_out_fifo.sv
// small output queue decoupling the pipeline from the downstream handshake
module bbd_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  bbd_pkg::rgb_item_t               push_item,
  input  logic                             pop,
  output logic                             not_empty,
  output bbd_pkg::rgb_item_t               head_item,
  output logic [bbd_pkg::FIFO_CNT_W-1:0]   count
);
  import bbd_pkg::*;

  rgb_item_t             entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  assign not_empty = (count != '0);
  assign head_item = entries[rd_ptr];

endmodule

// File: rtl/core/bayer_bilinear_demosaic_core.sv
// bilinear bayer demosaic: once the item that completes its 3x3 window is accepted, a result
// passes the line store, window and output queue registers, one line plus one pixel behind
// one item per clock while s_tready is high; each line memory does one read and one write per cycle
// a four-entry output queue absorbs stalls; input stalls once queue and pipeline hold four items
// reset restores width 640, height 480, pattern grbg and clears counters, window and queue
// line memories are not cleared; no result reads an entry not written in the current frame
module bayer_bilinear_demosaic_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // raw_pixel
  input  logic                            s_tuser,   // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // blue, green, red from msb down
  output logic                            m_tlast,   // end_of_frame
  input  logic                            cfg_we,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::DIM_W-1:0]       cfg_data
);
  import bbd_pkg::*;

  logic                  accept;
  logic [PIX_W-1:0]      px_in;
  logic [COL_W-1:0]      col;
  pix_ctl_t              ctl;
  pix_ctl_t              s1_ctl;
  logic                  s1_valid;
  logic [PIX_W-1:0]      s1_top;
  logic [PIX_W-1:0]      s1_mid;
  logic [PIX_W-1:0]      s1_px;
  logic                  push;
  rgb_item_t             push_item;
  rgb_item_t             head_item;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W:0]   in_flight;

  assign accept = s_tvalid && s_tready;
  assign px_in  = s_tuser ? '0 : s_tdata[PIX_W-1:0];

  // room for everything already in the pipeline plus one more item
  assign in_flight = (FIFO_CNT_W+1)'(count) + (FIFO_CNT_W+1)'(s1_valid)
                     + (FIFO_CNT_W+1)'(push);
  assign s_tready  = in_flight < (FIFO_CNT_W+1)'(FIFO_DEPTH);

  bbd_pos_ctrl u_pos_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .ctl       (ctl)
  );

  bbd_line_store u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_col   (col),
    .px_in    (px_in),
    .s1_valid (s1_valid),
    .s1_top   (s1_top),
    .s1_mid   (s1_mid),
    .s1_px    (s1_px)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
    end
  end

  bbd_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_top   (s1_top),
    .s1_mid   (s1_mid),
    .s1_px    (s1_px),
    .s1_ctl   (s1_ctl),
    .push     (push),
    .item     (push_item)
  );

  assign pop = m_tvalid && m_tready;

  bbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (m_tvalid),
    .head_item (head_item),
    .count     (count)
  );

  assign m_tdata = {head_item.blue, head_item.green, head_item.red};
  assign m_tlast = head_item.eof;

endmodule
